### hw/rtl/rrgi_pkg.sv
// ----------------------------------------------------------------------------
// rrgi_pkg
// Shared types and constants for the range row gap interpolator.
// ----------------------------------------------------------------------------
package rrgi_pkg;

    localparam int MAX_SPAN_DEF   = 3;
    localparam int COORD_BITS_DEF = 24;

    localparam int INT_W     = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 64;
    localparam int D2_W      = 34;

    localparam logic [CFG_W-1:0] MAX_ERR_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] BASE_ERR_RST   = 16'd300;
    localparam logic [CFG_W-1:0] HORIZ_FACT_RST = 16'd1144;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ERR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_FACT = 2'd2;

    // clamp of a per-axis difference in the distance check
    localparam logic [MUL_W-1:0] DIFF_CLAMP = 32'd65536;

    // steps of the limit check on the shared multiplier
    typedef enum logic [3:0] {
        STEP_DX  = 4'd0,
        STEP_DY  = 4'd1,
        STEP_DZ  = 4'd2,
        STEP_AX  = 4'd3,
        STEP_AY  = 4'd4,
        STEP_PX  = 4'd5,
        STEP_PY  = 4'd6,
        STEP_MM  = 4'd7,
        STEP_BB  = 4'd8,
        STEP_FS  = 4'd9,
        STEP_AA  = 4'd10,
        STEP_ALL = 4'd11,
        STEP_ALH = 4'd12,
        STEP_AHL = 4'd13,
        STEP_AHH = 4'd14
    } t_lstep;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LMUL  = 9'b000000010,
        S_LACC  = 9'b000000100,
        S_HELD  = 9'b000001000,
        S_IMUL  = 9'b000010000,
        S_ILD   = 9'b000100000,
        S_IDIV  = 9'b001000000,
        S_FEMIT = 9'b010000000,
        S_CUR   = 9'b100000000
    } t_state;

endpackage

### hw/rtl/range_row_gap_interpolator_unit.sv
// ----------------------------------------------------------------------------
// range_row_gap_interpolator_unit
// Fills short runs of invalid range-image points between two valid points.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake            | Beat contents
// ---------+-----------+----------------------+-------------------------------
// input    | in        | i_valid / o_ready    | point xyz, intensity, row end
// output   | out       | o_valid / i_ready    | xyz, intensity, row end, last
// config   | in        | i_cfg_we (no stall)  | register index, 16-bit data
//
// Flow: a held point is only stored, no beat goes out. A point that closes a run
// first goes through the limit check: 15 products on the shared 32x32 multiplier.
// Each filled point is then built axis by axis, a multiply by its place in the run
// and the bit-serial divider by the span, plus its output beat. Every other result
// goes out at one output beat per cycle while the output is not stalled.
// Reset is synchronous, active low; it clears control state and loads the
// register reset values. A stalled output holds the sequencer in its emit
// state; the last result may wait in the output register while the next
// input beat is taken.
// ----------------------------------------------------------------------------
module range_row_gap_interpolator_unit #(
    parameter int MAX_SPAN   = rrgi_pkg::MAX_SPAN_DEF,
    parameter int COORD_BITS = rrgi_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rrgi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rrgi_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [COORD_BITS-1:0]       i_point_x,
    input  logic signed [COORD_BITS-1:0]       i_point_y,
    input  logic signed [COORD_BITS-1:0]       i_point_z,
    input  logic [rrgi_pkg::INT_W-1:0]         i_intensity,
    input  logic                               i_end_of_row,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [COORD_BITS-1:0]       o_out_x,
    output logic signed [COORD_BITS-1:0]       o_out_y,
    output logic signed [COORD_BITS-1:0]       o_out_z,
    output logic [rrgi_pkg::INT_W-1:0]         o_out_intensity,
    output logic                               o_out_end_of_row,
    output logic                               o_run_last
);

    localparam int HOLD   = MAX_SPAN - 1;
    localparam int GAP_W  = $clog2(MAX_SPAN);
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int IDX_W  = (HOLD > 1) ? $clog2(HOLD) : 1;
    localparam int NUM_W  = COORD_BITS + SPAN_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int FS_W   = rrgi_pkg::CFG_W + SPAN_W;
    localparam int MW     = rrgi_pkg::MUL_W;
    localparam int PW     = rrgi_pkg::PROD_W;
    localparam int D2W    = rrgi_pkg::D2_W;

    // control
    rrgi_pkg::t_state r_state;
    rrgi_pkg::t_lstep r_step;
    logic                         r_ovalid;
    logic                         r_anc_valid;
    logic [GAP_W-1:0]             r_gap;
    logic [IDX_W-1:0]             r_idx;
    logic [1:0]                   r_axis;
    logic [CNT_W-1:0]             r_dcnt;

    // configuration
    logic [rrgi_pkg::CFG_W-1:0]   r_max_err;
    logic [rrgi_pkg::CFG_W-1:0]   r_base_err;
    logic [rrgi_pkg::CFG_W-1:0]   r_factor;

    // payload
    logic signed [COORD_BITS-1:0] r_pt  [0:2];
    logic signed [COORD_BITS-1:0] r_anc [0:2];
    logic signed [COORD_BITS-1:0] r_res [0:2];
    logic signed [COORD_BITS-1:0] r_held [0:HOLD-1][0:2];
    logic [rrgi_pkg::INT_W-1:0]   r_inten;
    logic                         r_eor;

    // arithmetic
    logic [PW-1:0]                r_prod;
    logic [D2W-1:0]               r_d2;
    logic [PW-1:0]                r_r1;
    logic [PW-1:0]                r_rsq;
    logic [MW-1:0]                r_m2;
    logic [MW-1:0]                r_b2;
    logic [FS_W-1:0]              r_fs;
    logic [PW-1:0]                r_a;
    logic [D2W-1:0]               r_ht;
    logic                         r_lonz;
    logic                         r_sat;
    logic [NUM_W-1:0]             r_num;
    logic [SPAN_W-1:0]            r_rem;

    // output register
    logic signed [COORD_BITS-1:0] r_ox, r_oy, r_oz;
    logic [rrgi_pkg::INT_W-1:0]   r_oint;
    logic                         r_oeor;
    logic                         r_olast;

    logic [COORD_BITS-1:0]        mag [0:2];
    logic                         neg [0:2];
    logic [MW-1:0]                clampd [0:2];
    logic signed [COORD_BITS:0]   diff [0:2];
    logic [MW-1:0]                mul_a, mul_b;
    logic [PW-1:0]                mul_p;
    logic [PW-1:0]                r2_sum;
    logic [SPAN_W-1:0]            span, kval;
    logic                         sat_n, fill;
    logic [SPAN_W:0]              trial;
    logic                         qbit;
    logic [SPAN_W-1:0]            rem_n;
    logic [NUM_W-1:0]             n_num;
    logic signed [COORD_BITS:0]   anc_ext, q_ext, coord_sum;
    logic                         out_free, idx_last;
    logic                         out_load;
    logic [IDX_W-1:0]             widx;

    function automatic logic [COORD_BITS-1:0] f_abs(input logic signed [COORD_BITS-1:0] v);
        return v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
    endfunction

    assign span     = SPAN_W'(r_gap) + SPAN_W'(1);
    assign kval     = SPAN_W'(r_idx) + SPAN_W'(1);
    assign out_free = !r_ovalid || i_ready;
    assign idx_last = (GAP_W'(r_idx) == (r_gap - GAP_W'(1)));
    assign widx     = r_gap[IDX_W-1:0];
    // an emit state loads the output register this cycle
    assign out_load = out_free &&
                      (r_state inside {rrgi_pkg::S_FEMIT, rrgi_pkg::S_HELD, rrgi_pkg::S_CUR});

    // per-axis distance between latched point and anchor
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i]   = {r_pt[i][COORD_BITS-1], r_pt[i]} - {r_anc[i][COORD_BITS-1], r_anc[i]};
            neg[i]    = diff[i][COORD_BITS];
            mag[i]    = neg[i] ? COORD_BITS'(-diff[i]) : COORD_BITS'(diff[i]);
            clampd[i] = (MW'(mag[i]) > rrgi_pkg::DIFF_CLAMP) ? rrgi_pkg::DIFF_CLAMP
                                                            : MW'(mag[i]);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == rrgi_pkg::S_IMUL) begin
            mul_a = MW'(mag[r_axis]);
            mul_b = MW'(kval);
        end else begin
            case (r_step)
                rrgi_pkg::STEP_DX:  begin mul_a = clampd[0]; mul_b = clampd[0]; end
                rrgi_pkg::STEP_DY:  begin mul_a = clampd[1]; mul_b = clampd[1]; end
                rrgi_pkg::STEP_DZ:  begin mul_a = clampd[2]; mul_b = clampd[2]; end
                rrgi_pkg::STEP_AX:  begin
                    mul_a = MW'(f_abs(r_anc[0])); mul_b = MW'(f_abs(r_anc[0]));
                end
                rrgi_pkg::STEP_AY:  begin
                    mul_a = MW'(f_abs(r_anc[1])); mul_b = MW'(f_abs(r_anc[1]));
                end
                rrgi_pkg::STEP_PX:  begin
                    mul_a = MW'(f_abs(r_pt[0])); mul_b = MW'(f_abs(r_pt[0]));
                end
                rrgi_pkg::STEP_PY:  begin
                    mul_a = MW'(f_abs(r_pt[1])); mul_b = MW'(f_abs(r_pt[1]));
                end
                rrgi_pkg::STEP_MM:  begin mul_a = MW'(r_max_err);  mul_b = MW'(r_max_err);  end
                rrgi_pkg::STEP_BB:  begin mul_a = MW'(r_base_err); mul_b = MW'(r_base_err); end
                rrgi_pkg::STEP_FS:  begin mul_a = MW'(r_factor);   mul_b = MW'(span);       end
                rrgi_pkg::STEP_AA:  begin mul_a = MW'(r_fs);       mul_b = MW'(r_fs);       end
                rrgi_pkg::STEP_ALL: begin mul_a = r_a[MW-1:0];  mul_b = r_rsq[MW-1:0];  end
                rrgi_pkg::STEP_ALH: begin mul_a = r_a[MW-1:0];  mul_b = r_rsq[PW-1:MW]; end
                rrgi_pkg::STEP_AHL: begin mul_a = r_a[PW-1:MW]; mul_b = r_rsq[MW-1:0];  end
                rrgi_pkg::STEP_AHH: begin mul_a = r_a[PW-1:MW]; mul_b = r_rsq[PW-1:MW]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign r2_sum = r_rsq + r_prod;

    // limit decision: d2 < max_err^2 and (d2 < base^2 or d2 < ceil(a*r / 2^32))
    assign sat_n = r_sat | (|r_prod);
    assign fill  = (r_d2 < D2W'(r_m2)) &&
                   ((r_d2 < D2W'(r_b2)) || sat_n ||
                    ({1'b0, r_d2} < ({1'b0, r_ht} + (D2W+1)'(r_lonz))));

    // restoring divide step and coordinate rebuild
    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign qbit      = (trial >= {1'b0, span});
    assign rem_n     = qbit ? SPAN_W'(trial - {1'b0, span}) : SPAN_W'(trial);
    assign n_num     = {r_num[NUM_W-2:0], qbit};
    assign anc_ext   = {r_anc[r_axis][COORD_BITS-1], r_anc[r_axis]};
    assign q_ext     = {1'b0, n_num[COORD_BITS-1:0]};
    assign coord_sum = neg[r_axis] ? (anc_ext - q_ext) : (anc_ext + q_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrgi_pkg::S_IDLE;
            r_step      <= rrgi_pkg::STEP_DX;
            r_ovalid    <= 1'b0;
            r_anc_valid <= 1'b0;
            r_gap       <= '0;
            r_idx       <= '0;
            r_axis      <= '0;
            r_dcnt      <= '0;
            r_max_err   <= rrgi_pkg::MAX_ERR_RST;
            r_base_err  <= rrgi_pkg::BASE_ERR_RST;
            r_factor    <= rrgi_pkg::HORIZ_FACT_RST;
        end else begin
            if (r_ovalid && i_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrgi_pkg::REG_MAX_ERR:    r_max_err  <= i_cfg_data;
                    rrgi_pkg::REG_BASE_ERR:   r_base_err <= i_cfg_data;
                    rrgi_pkg::REG_HORIZ_FACT: r_factor   <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                rrgi_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_pt[0] <= i_point_x;
                        r_pt[1] <= i_point_y;
                        r_pt[2] <= i_point_z;
                        r_inten <= i_intensity;
                        r_eor   <= i_end_of_row;
                        r_idx   <= '0;
                        r_axis  <= '0;
                        r_step  <= rrgi_pkg::STEP_DX;
                        if (i_intensity != '0) begin
                            r_state <= (r_anc_valid && r_gap != '0) ? rrgi_pkg::S_LMUL
                                                                    : rrgi_pkg::S_CUR;
                        end else if (r_anc_valid && !i_end_of_row &&
                                     r_gap < GAP_W'(HOLD)) begin
                            // hold the point, no beat goes out
                            r_held[widx][0] <= i_point_x;
                            r_held[widx][1] <= i_point_y;
                            r_held[widx][2] <= i_point_z;
                            r_gap           <= r_gap + GAP_W'(1);
                        end else begin
                            r_state <= (r_gap != '0) ? rrgi_pkg::S_HELD : rrgi_pkg::S_CUR;
                        end
                    end
                end

                rrgi_pkg::S_LMUL: begin
                    r_prod  <= mul_p;
                    r_state <= rrgi_pkg::S_LACC;
                end

                rrgi_pkg::S_LACC: begin
                    case (r_step)
                        rrgi_pkg::STEP_DX:  r_d2  <= r_prod[D2W-1:0];
                        rrgi_pkg::STEP_DY,
                        rrgi_pkg::STEP_DZ:  r_d2  <= r_d2 + r_prod[D2W-1:0];
                        rrgi_pkg::STEP_AX:  r_r1  <= r_prod;
                        rrgi_pkg::STEP_AY:  r_r1  <= r_r1 + r_prod;
                        rrgi_pkg::STEP_PX:  r_rsq <= r_prod;
                        rrgi_pkg::STEP_PY:  r_rsq <= (r_r1 > r2_sum) ? r_r1 : r2_sum;
                        rrgi_pkg::STEP_MM:  r_m2  <= r_prod[MW-1:0];
                        rrgi_pkg::STEP_BB:  r_b2  <= r_prod[MW-1:0];
                        rrgi_pkg::STEP_FS:  r_fs  <= r_prod[FS_W-1:0];
                        rrgi_pkg::STEP_AA:  r_a   <= r_prod;
                        rrgi_pkg::STEP_ALL: begin
                            r_ht   <= D2W'(r_prod[PW-1:MW]);
                            r_lonz <= |r_prod[MW-1:0];
                            r_sat  <= 1'b0;
                        end
                        rrgi_pkg::STEP_ALH,
                        rrgi_pkg::STEP_AHL: begin
                            r_sat <= r_sat | (|r_prod[PW-1:MW]);
                            r_ht  <= r_ht + D2W'(r_prod[MW-1:0]);
                        end
                        default: ;
                    endcase
                    if (r_step == rrgi_pkg::STEP_AHH) begin
                        r_state <= fill ? rrgi_pkg::S_IMUL : rrgi_pkg::S_HELD;
                    end else begin
                        r_step  <= rrgi_pkg::t_lstep'(r_step + 4'd1);
                        r_state <= rrgi_pkg::S_LMUL;
                    end
                end

                rrgi_pkg::S_IMUL: begin
                    r_prod  <= mul_p;
                    r_state <= rrgi_pkg::S_ILD;
                end

                rrgi_pkg::S_ILD: begin
                    r_num   <= r_prod[NUM_W-1:0];
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= rrgi_pkg::S_IDIV;
                end

                rrgi_pkg::S_IDIV: begin
                    r_num  <= n_num;
                    r_rem  <= rem_n;
                    r_dcnt <= r_dcnt + CNT_W'(1);
                    if (r_dcnt == CNT_W'(NUM_W - 1)) begin
                        r_res[r_axis] <= coord_sum[COORD_BITS-1:0];
                        if (r_axis == 2'd2) begin
                            r_axis  <= '0;
                            r_state <= rrgi_pkg::S_FEMIT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= rrgi_pkg::S_IMUL;
                        end
                    end
                end

                rrgi_pkg::S_FEMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_res[0];
                        r_oy     <= r_res[1];
                        r_oz     <= r_res[2];
                        r_oint   <= rrgi_pkg::INT_W'(1);
                        r_oeor   <= 1'b0;
                        r_olast  <= 1'b0;
                        if (idx_last) begin
                            r_state <= rrgi_pkg::S_CUR;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= rrgi_pkg::S_IMUL;
                        end
                    end
                end

                rrgi_pkg::S_HELD: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_held[r_idx][0];
                        r_oy     <= r_held[r_idx][1];
                        r_oz     <= r_held[r_idx][2];
                        r_oint   <= '0;
                        r_oeor   <= 1'b0;
                        r_olast  <= 1'b0;
                        if (idx_last) begin
                            r_state <= rrgi_pkg::S_CUR;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end

                rrgi_pkg::S_CUR: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_pt[0];
                        r_oy     <= r_pt[1];
                        r_oz     <= r_pt[2];
                        r_oint   <= r_inten;
                        r_oeor   <= r_eor;
                        r_olast  <= 1'b1;
                        r_gap    <= '0;
                        // a valid point becomes the anchor unless it ends the row
                        if (r_inten != '0) begin
                            r_anc       <= r_pt;
                            r_anc_valid <= !r_eor;
                        end else begin
                            r_anc_valid <= 1'b0;
                        end
                        r_state <= rrgi_pkg::S_IDLE;
                    end
                end

                default: r_state <= rrgi_pkg::S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == rrgi_pkg::S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_out_x          = r_ox;
    assign o_out_y          = r_oy;
    assign o_out_z          = r_oz;
    assign o_out_intensity  = r_oint;
    assign o_out_end_of_row = r_oeor;
    assign o_run_last       = r_olast;

`ifndef SYNTHESIS
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap <= GAP_W'(HOLD))
        else $error("held count beyond hold depth");

    a_gap_needs_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_anc_valid |-> (r_gap == '0))
        else $error("points held without an anchor");

    a_hold_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_intensity == '0 && r_anc_valid && !i_end_of_row &&
         r_gap < GAP_W'(HOLD)) |=> (r_gap == GAP_W'($past(r_gap) + GAP_W'(1))))
        else $error("held point not counted");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrgi_pkg::S_IDIV) |-> (r_dcnt < CNT_W'(NUM_W)))
        else $error("divider ran past its width");
`endif

endmodule

### tb/range_row_gap_interpolator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_row_gap_interpolator_unit_tb
// Self-checking bench for the range row gap interpolator. A short directed
// table opens the run. Random rows of anchors, gaps and closing points follow
// under several register settings and idle patterns. Every output beat is
// compared against an in-bench model of the gap filling.
// ----------------------------------------------------------------------------
module range_row_gap_interpolator_unit_tb;

    localparam int CB    = rrgi_pkg::COORD_BITS_DEF;
    localparam int DEPTH = rrgi_pkg::MAX_SPAN_DEF - 1;
    // index past the last register; writes to it must be ignored
    localparam logic [rrgi_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum int {SEQ_FILL, SEQ_LONG, SEQ_ROW_END, SEQ_NOISE} t_seq;

    typedef struct {
        logic signed [CB-1:0]           x, y, z;
        logic [rrgi_pkg::INT_W-1:0]     inten;
        logic                           eor;
        logic                           last;
    } t_point_out;

    typedef struct {
        logic signed [CB-1:0]           x, y, z;
        logic [rrgi_pkg::INT_W-1:0]     inten;
        logic                           eor;
        int                             n_res;    // expected result count, -1 = model only
        int                             last_int; // expected last intensity, -1 = model only
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [rrgi_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rrgi_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic signed [CB-1:0]           i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic [rrgi_pkg::INT_W-1:0]     i_intensity = '0;
    logic                           i_end_of_row = 1'b0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic signed [CB-1:0]           o_out_x, o_out_y, o_out_z;
    logic [rrgi_pkg::INT_W-1:0]     o_out_intensity;
    logic                           o_out_end_of_row;
    logic                           o_run_last;

    // side-band of the directed table, driven along with each beat
    int tbl_n = -1;
    int tbl_int = -1;

    range_row_gap_interpolator_unit uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("range_row_gap_interpolator_unit_tb: FAIL");
        $finish;
    end

    // ---------------- model state ----------------
    logic [rrgi_pkg::CFG_W-1:0] max_err, base_err, horiz_fact;
    longint           anc_x, anc_y, anc_z;
    bit               anc_valid;
    int               gap_cnt;
    longint           held_x[DEPTH], held_y[DEPTH], held_z[DEPTH];

    t_point_out pending_pts[$];
    int         err_count = 0;
    int         n_beats_in = 0, n_beats_out = 0, n_filled = 0;
    int         send_idle_pct = 0, stall_pct = 0;

    function automatic longint unsigned clamp_mag(longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : d;
        return (m > 65536) ? 65536 : m;
    endfunction

    // Distance of the closing point from the anchor against the error limit.
    function automatic bit gap_fits(longint bx, longint by, longint bz, int span);
        longint unsigned dx, dy, dz, d2, r1, r2, r, m2, b2, fs, a, term, lim, cap;
        dx   = clamp_mag(bx - anc_x);
        dy   = clamp_mag(by - anc_y);
        dz   = clamp_mag(bz - anc_z);
        d2   = dx * dx + dy * dy + dz * dz;
        r1   = anc_x * anc_x + anc_y * anc_y;
        r2   = bx * bx + by * by;
        r    = (r1 > r2) ? r1 : r2;
        m2   = longint'(max_err) * max_err;
        b2   = longint'(base_err) * base_err;
        fs   = longint'(horiz_fact) * span;
        a    = fs * fs;
        term = 0;
        if (a != 0 && r != 0) begin
            cap = m2 << 32;
            if (r > cap / a)
                term = m2;
            else
                term = (a * r + 64'hFFFF_FFFF) >> 32;
        end
        lim = (b2 > term) ? b2 : term;
        if (lim > m2)
            lim = m2;
        return d2 < lim;
    endfunction

    function automatic void queue_point(longint x, longint y, longint z,
                                        logic [rrgi_pkg::INT_W-1:0] inten, logic eor);
        t_point_out p;
        p.x = x[CB-1:0];
        p.y = y[CB-1:0];
        p.z = z[CB-1:0];
        p.inten = inten;
        p.eor = eor;
        p.last = 1'b0;
        pending_pts.push_back(p);
    endfunction

    // Advance the model by one input beat; return how many points it releases.
    function automatic int predict_points(longint px, longint py, longint pz,
                                          logic [rrgi_pkg::INT_W-1:0] inten, logic eor);
        int  n0;
        int  span;
        bit  fill;
        n0 = pending_pts.size();
        if (inten != 0) begin
            if (anc_valid && gap_cnt > 0) begin
                span = gap_cnt + 1;
                fill = gap_fits(px, py, pz, span);
                for (int i = 0; i < gap_cnt; i++) begin
                    if (fill) begin
                        queue_point(anc_x + (px - anc_x) * (i + 1) / span,
                                    anc_y + (py - anc_y) * (i + 1) / span,
                                    anc_z + (pz - anc_z) * (i + 1) / span, 8'd1, 1'b0);
                        n_filled++;
                    end else begin
                        queue_point(held_x[i], held_y[i], held_z[i], 8'd0, 1'b0);
                    end
                end
            end
            queue_point(px, py, pz, inten, eor);
            anc_x = px;
            anc_y = py;
            anc_z = pz;
            anc_valid = !eor;
            gap_cnt = 0;
        end else if (anc_valid && !eor && gap_cnt < DEPTH) begin
            // hold the point until the gap closes
            held_x[gap_cnt] = px;
            held_y[gap_cnt] = py;
            held_z[gap_cnt] = pz;
            gap_cnt++;
        end else begin
            // flush the held run unfilled and drop the anchor
            for (int i = 0; i < gap_cnt; i++)
                queue_point(held_x[i], held_y[i], held_z[i], 8'd0, 1'b0);
            queue_point(px, py, pz, 8'd0, eor);
            anc_valid = 0;
            gap_cnt = 0;
        end
        if (pending_pts.size() > n0)
            pending_pts[pending_pts.size() - 1].last = 1'b1;
        return pending_pts.size() - n0;
    endfunction

    // Track register writes and accepted input beats.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            max_err = rrgi_pkg::MAX_ERR_RST;
            base_err = rrgi_pkg::BASE_ERR_RST;
            horiz_fact = rrgi_pkg::HORIZ_FACT_RST;
            anc_x = 0;
            anc_y = 0;
            anc_z = 0;
            anc_valid = 0;
            gap_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrgi_pkg::REG_MAX_ERR:    max_err = i_cfg_data;
                    rrgi_pkg::REG_BASE_ERR:   base_err = i_cfg_data;
                    rrgi_pkg::REG_HORIZ_FACT: horiz_fact = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                n_beats_in++;
                n = predict_points(i_point_x, i_point_y, i_point_z, i_intensity,
                                   i_end_of_row);
                // hand-written table entries cross-check the model itself
                if (tbl_n >= 0 && n != tbl_n) begin
                    $error("result count: expected %0d, actual %0d", tbl_n, n);
                    err_count++;
                end
                if (tbl_int >= 0 && n > 0
                        && pending_pts[pending_pts.size() - 1].inten != tbl_int) begin
                    $error("last intensity: expected %0d, actual %0d", tbl_int,
                           pending_pts[pending_pts.size() - 1].inten);
                    err_count++;
                end
            end
        end
    end

    function automatic void check_field(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0d, actual %0d", name, e, a);
            err_count++;
        end
    endfunction

    // Compare each output beat against the oldest expected point.
    always @(posedge i_clk) begin
        t_point_out e;
        if (i_rst_n && o_valid && i_ready) begin
            n_beats_out++;
            if (pending_pts.size() == 0) begin
                $error("output beat with no expected point");
                err_count++;
            end else begin
                e = pending_pts.pop_front();
                check_field("out_x", e.x, o_out_x);
                check_field("out_y", e.y, o_out_y);
                check_field("out_z", e.z, o_out_z);
                check_field("out_intensity", e.inten, o_out_intensity);
                check_field("out_end_of_row", e.eor, o_out_end_of_row);
                check_field("run_last", e.last, o_run_last);
            end
        end
    end

    // Receiver: stall at the phase's rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------- stimulus ----------------
    task automatic send_beat(logic signed [CB-1:0] x, y, z,
                             logic [rrgi_pkg::INT_W-1:0] inten,
                             logic eor, int n_res = -1, int last_int = -1);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        i_intensity <= inten;
        i_end_of_row <= eor;
        tbl_n <= n_res;
        tbl_int <= last_int;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic cfg_write(logic [rrgi_pkg::CFG_IDX_W-1:0] idx,
                             logic [rrgi_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait out every expected point and any held-point work.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_pts.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(3))
            0:       return CB'($urandom);
            1:       return $urandom_range(1, 0) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'(int'($urandom_range(8000)) - 4000);
        endcase
    endfunction

    function automatic logic signed [CB-1:0] near(logic signed [CB-1:0] c);
        int d;
        d = $urandom_range(1) ? $urandom_range(60) : $urandom_range(3000);
        return CB'(c + ($urandom_range(1) ? d : -d));
    endfunction

    task automatic send_sequence(t_seq kind);
        logic signed [CB-1:0] ax, ay, az;
        int g;
        ax = rand_coord();
        ay = rand_coord();
        az = rand_coord();
        if (kind == SEQ_NOISE) begin
            send_beat(ax, ay, az, $urandom_range(1) ? 8'd0 : 8'($urandom),
                      $urandom_range(3) == 0);
            return;
        end
        send_beat(ax, ay, az, rrgi_pkg::INT_W'($urandom_range(1, 255)), 1'b0);
        g = (kind == SEQ_LONG) ? DEPTH + 1 : $urandom_range(1, DEPTH);
        for (int i = 0; i < g; i++)
            send_beat(CB'($urandom), CB'($urandom), CB'($urandom), 8'd0,
                      kind == SEQ_ROW_END && i == g - 1);
        if (kind != SEQ_ROW_END)
            send_beat(near(ax), near(ay), near(az),
                      rrgi_pkg::INT_W'($urandom_range(1, 255)),
                      $urandom_range(7) == 0);
    endtask

    localparam int N_DIR = 17;
    t_row dir_rows[N_DIR] = '{
        // no anchor: an invalid point passes at once
        '{24'sd0, 24'sd0, 24'sd0, 8'd0, 1'b0, 1, 0},
        '{24'sd1000, 24'sd0, 24'sd0, 8'd200, 1'b0, 1, 200},
        '{24'sd5, 24'sd5, 24'sd5, 8'd0, 1'b0, 0, -1},
        // close within the base limit: the held point is filled
        '{24'sd1100, 24'sd0, 24'sd0, 8'd50, 1'b0, 2, 50},
        '{24'sd1, 24'sd2, 24'sd3, 8'd0, 1'b0, 0, -1},
        '{24'sd4, 24'sd5, 24'sd6, 8'd0, 1'b0, 0, -1},
        // run too long: flush two held points and this one
        '{24'sd7, 24'sd8, 24'sd9, 8'd0, 1'b0, 3, 0},
        '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 8'd255, 1'b0, 1, 255},
        '{24'sd0, 24'sd0, 24'sd0, 8'd0, 1'b0, 0, -1},
        // far closing point: held point leaves unfilled
        '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 8'd1, 1'b0, 2, 1},
        '{24'sd11, 24'sd12, 24'sd13, 8'd0, 1'b0, 0, -1},
        // row end on an invalid point: flush the gap
        '{24'sd14, 24'sd15, 24'sd16, 8'd0, 1'b1, 2, 0},
        '{24'sd0, 24'sd0, 24'sd0, 8'd9, 1'b1, 1, 9},
        '{24'sd3, 24'sd3, 24'sd3, 8'd0, 1'b0, 1, 0},
        '{24'sd0, 24'sd0, 24'sd0, 8'd7, 1'b0, 1, 7},
        '{24'sd0, 24'sd0, 24'sd0, 8'd0, 1'b0, 0, -1},
        // row end on a valid point that still closes the run
        '{24'sd0, 24'sd0, 24'sd0, 8'd8, 1'b1, 2, 8}
    };

    initial begin
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].inten,
                      dir_rows[i].eor, dir_rows[i].n_res, dir_rows[i].last_int);
        tbl_n <= -1;
        tbl_int <= -1;
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: begin
                    cfg_write(rrgi_pkg::REG_MAX_ERR, 16'hFFFF);
                    cfg_write(rrgi_pkg::REG_BASE_ERR, 16'h0000);
                    cfg_write(rrgi_pkg::REG_HORIZ_FACT, 16'hFFFF);
                end
                2: begin
                    cfg_write(rrgi_pkg::REG_MAX_ERR, 16'h0000);
                    cfg_write(rrgi_pkg::REG_BASE_ERR, 16'hFFFF);
                    cfg_write(rrgi_pkg::REG_HORIZ_FACT, 16'h0000);
                end
                3: begin
                    cfg_write(rrgi_pkg::REG_MAX_ERR, 16'hFFFF);
                    cfg_write(rrgi_pkg::REG_BASE_ERR, 16'hFFFF);
                    cfg_write(rrgi_pkg::REG_HORIZ_FACT, rrgi_pkg::HORIZ_FACT_RST);
                    cfg_write(REG_NONE, 16'h1234);
                end
                4: begin
                    cfg_write(rrgi_pkg::REG_MAX_ERR, 16'd2000);
                    cfg_write(rrgi_pkg::REG_BASE_ERR, 16'd100);
                    cfg_write(rrgi_pkg::REG_HORIZ_FACT, 16'd30000);
                end
                5: begin
                    cfg_write(rrgi_pkg::REG_MAX_ERR, rrgi_pkg::CFG_W'($urandom));
                    cfg_write(rrgi_pkg::REG_BASE_ERR, rrgi_pkg::CFG_W'($urandom_range(500)));
                    cfg_write(rrgi_pkg::REG_HORIZ_FACT, rrgi_pkg::CFG_W'($urandom));
                end
                default: ;
            endcase
            // idle pattern: none, sender, receiver, both
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            while (n_beats_in < N_DIR + 60 * (p + 1)) begin
                r = $urandom_range(99);
                if (r < 65)
                    send_sequence(SEQ_FILL);
                else if (r < 75)
                    send_sequence(SEQ_LONG);
                else if (r < 85)
                    send_sequence(SEQ_ROW_END);
                else
                    send_sequence(SEQ_NOISE);
            end
            drain();
        end

        if (pending_pts.size() != 0) begin
            $error("%0d expected points never arrived", pending_pts.size());
            err_count++;
        end
        $display("Covered %0d input beats and %0d output beats (%0d filled points)",
                 n_beats_in, n_beats_out, n_filled);
        $display("over six register settings and four idle patterns; %0d errors",
                 err_count);
        if (err_count == 0)
            $display("range_row_gap_interpolator_unit_tb: PASS");
        else
            $display("range_row_gap_interpolator_unit_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rrgi_pkg.sv
hw/rtl/range_row_gap_interpolator_unit.sv
tb/range_row_gap_interpolator_unit_tb.sv
